// ----- hw/rtl/txc_pkg.sv -----
package txc_pkg;

  // operation codes on the input channel
  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_SETCUR = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // character codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  localparam int TAB_STEP = 8;

  localparam logic [7:0] ATTR_RESET = 8'd15;

  // widest cursor fields over the whole parameter range
  localparam int CMD_COL_W = 7;
  localparam int CMD_ROW_W = 6;
  localparam int CMD_IDX_W = 11;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [3:0] {
    K_NOP    = 4'd0,
    K_BS     = 4'd1,
    K_TAB    = 4'd2,
    K_CR     = 4'd3,
    K_LF     = 4'd4,
    K_PRINT  = 4'd5,
    K_READ   = 4'd6,
    K_SETCUR = 4'd7,
    K_CLEAR  = 4'd8
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             char_code;
    logic [CMD_IDX_W-1:0]   cell_index;
    logic [CMD_COL_W-1:0]   column;
    logic [CMD_ROW_W-1:0]   row;
  } txc_cmd_t;

  typedef struct packed {
    logic     valid;
    txc_cmd_t cmd;
  } txc_q_t;

endpackage

// ----- hw/rtl/txc_front.sv -----
module txc_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_char_code,
  input  logic [10:0]      in_cell_index,
  input  logic [6:0]       in_new_column,
  input  logic [4:0]       in_new_row,
  input  logic             init_busy,
  input  logic             cmd_pop,
  output txc_pkg::txc_q_t  cmd_q
);
  import txc_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  txc_cmd_t            cmd_new;
  txc_cmd_t            q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                push;
  logic                pop;

  // classify the request and clamp the cursor fields to the screen
  always_comb begin
    cmd_new.kind       = K_NOP;
    cmd_new.char_code  = in_char_code;
    cmd_new.cell_index = in_cell_index;
    cmd_new.column     = (int'(in_new_column) > COLUMNS - 1) ?
                         CMD_COL_W'(COLUMNS - 1) : in_new_column;
    cmd_new.row        = (int'(in_new_row) > ROWS - 1) ?
                         CMD_ROW_W'(ROWS - 1) : CMD_ROW_W'(in_new_row);
    case (in_operation)
      OP_PUT: begin
        case (in_char_code) inside
          CH_BS:             cmd_new.kind = K_BS;
          CH_TAB:            cmd_new.kind = K_TAB;
          CH_CR:             cmd_new.kind = K_CR;
          CH_LF:             cmd_new.kind = K_LF;
          [CH_SPACE:CH_DEL]: cmd_new.kind = K_PRINT;
          default:           cmd_new.kind = K_NOP;
        endcase
      end
      OP_READ: begin
        // out of range reads answer zero without touching the store
        cmd_new.kind = (int'(in_cell_index) < CELLS) ? K_READ : K_NOP;
      end
      OP_SETCUR: cmd_new.kind = K_SETCUR;
      OP_CLEAR:  cmd_new.kind = K_CLEAR;
      default:   cmd_new.kind = K_NOP;
    endcase
  end

  assign in_stall = (count_r == QCNT_W'(QUEUE_DEPTH)) || init_busy;
  assign push     = in_valid && !in_stall;
  assign pop      = cmd_pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (int'(wr_ptr_r) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (int'(rd_ptr_r) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_new;
    end
  end

  assign cmd_q.valid = (count_r != '0);
  assign cmd_q.cmd   = q_r[rd_ptr_r];

endmodule

// ----- hw/rtl/txc_back.sv -----
module txc_back #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       attr,
  input  txc_pkg::txc_q_t  cmd_q,
  output logic             cmd_pop,
  output logic             init_busy,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [10:0]      out_cursor_location,
  output logic [15:0]      out_cell_value
);
  import txc_pkg::*;

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int COLX_W = COL_W + 1;
  localparam int ROW_W  = $clog2(ROWS);

  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(COLUMNS);
  localparam logic [COLX_W-1:0] COL_LIMIT   = COLX_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  ROW_LAST    = ROW_W'(ROWS - 1);

  typedef enum logic [5:0] {
    ST_INIT   = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_RESP   = 6'b000100,
    ST_SCROLL = 6'b001000,
    ST_FILL   = 6'b010000,
    ST_SPARE  = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic               rd_flag_r, rd_flag_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [10:0]        out_loc_r, out_loc_nxt;
  logic [15:0]        out_cell_r, out_cell_nxt;

  logic [15:0]        cells_r [CELLS];
  logic [15:0]        rdata_r;
  logic               mem_we, mem_re;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [15:0]        mem_wdata;

  logic [ADDR_W-1:0]  lin;
  logic [COLX_W-1:0]  col_t;
  logic               row_inc;
  logic [15:0]        blank;
  txc_cmd_t           cmd;

  assign cmd   = cmd_q.cmd;
  assign blank = {attr, CH_SPACE};
  assign lin   = ADDR_W'(int'(row_r) * COLUMNS + int'(col_r));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    rd_flag_nxt   = rd_flag_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_loc_nxt   = out_loc_r;
    out_cell_nxt  = out_cell_r;
    mem_we        = 1'b0;
    mem_waddr     = cnt_r;
    mem_wdata     = blank;
    mem_re        = 1'b0;
    mem_raddr     = ADDR_W'(cmd.cell_index);
    cmd_pop       = 1'b0;
    col_t         = {1'b0, col_r};
    row_inc       = 1'b0;

    case (state_r)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {ATTR_RESET, CH_SPACE};
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_q.valid) begin
          cmd_pop     = 1'b1;
          rd_flag_nxt = (cmd.kind == K_READ);
          state_nxt   = ST_RESP;
          case (cmd.kind)
            K_BS: begin
              if (col_r != '0) begin
                col_t     = col_t - 1'b1;
                mem_we    = 1'b1;
                mem_waddr = lin - 1'b1;
              end
            end
            K_TAB: begin
              col_t = (col_t + COLX_W'(TAB_STEP)) & ~COLX_W'(TAB_STEP - 1);
            end
            K_CR: col_t = '0;
            K_LF: begin
              col_t   = '0;
              row_inc = 1'b1;
            end
            K_PRINT: begin
              mem_we    = 1'b1;
              mem_waddr = lin;
              mem_wdata = {attr, cmd.char_code};
              col_t     = col_t + 1'b1;
            end
            K_READ:  mem_re = 1'b1;
            K_SETCUR: ;
            K_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = ST_FILL;
            end
            default: ;
          endcase
          // wrap past the last column
          if (col_t >= COL_LIMIT) begin
            col_t   = '0;
            row_inc = 1'b1;
          end
          col_nxt = COL_W'(col_t);
          if (row_inc) begin
            if (row_r == ROW_LAST) begin
              cnt_nxt   = '0;
              state_nxt = ST_SCROLL;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
          if (cmd.kind == K_SETCUR) begin
            col_nxt = COL_W'(cmd.column);
            row_nxt = ROW_W'(cmd.row);
          end
        end
      end

      ST_SCROLL: begin
        // read one row ahead, write the previous read one slot behind
        if (cnt_r != SCROLL_LAST) begin
          mem_re    = 1'b1;
          mem_raddr = cnt_r + ROW_STEP;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          state_nxt = ST_FILL;
        end
        if (cnt_r != '0) begin
          mem_we    = 1'b1;
          mem_waddr = cnt_r - 1'b1;
          mem_wdata = rdata_r;
        end
      end

      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt_r == LAST_CELL) begin
          cnt_nxt   = '0;
          state_nxt = ST_RESP;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_loc_nxt   = 11'(lin);
          out_cell_nxt  = rd_flag_r ? rdata_r : 16'd0;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      rd_flag_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      rd_flag_r   <= rd_flag_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_loc_r  <= out_loc_nxt;
    out_cell_r <= out_cell_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cells_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= cells_r[mem_raddr];
    end
  end

  assign init_busy           = (state_r == ST_INIT);
  assign out_valid           = out_valid_r;
  assign out_cursor_location = out_loc_r;
  assign out_cell_value      = out_cell_r;

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(col_r) < COLUMNS)
    else $error("cursor column out of range");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(row_r) < ROWS)
    else $error("cursor row out of range");

  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCROLL |-> row_r == ROW_LAST)
    else $error("scroll with cursor off the bottom row");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP && out_valid_r && out_stall) |=> state_r == ST_RESP)
    else $error("result dropped while output stalled");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INIT || state_r == ST_SCROLL || state_r == ST_FILL) |-> !cmd_pop)
    else $error("request taken during a memory sweep");
`endif

endmodule

// ----- hw/rtl/text_console_character_writer_unit.sv -----
// Text console of COLUMNS x ROWS 16-bit cells (attribute high byte, character low
// byte) with a cursor. A front stage classifies each request into a two-entry
// queue; a back sequencer owns the cursor and the single-port-write cell memory.
// Put, read and set-cursor requests each pass an execute step and a result step in
// the back sequencer. A scroll moves the screen one cell per cycle and then blanks
// the bottom row; clear screen blanks every cell and then gives its result. After
// reset the memory is blanked, during which in_stall stays high; attribute writes
// are taken any time and affect only later writes, scrolls and clears.
module text_console_character_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  input  logic [6:0]  in_new_column,
  input  logic [4:0]  in_new_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] out_cursor_location,
  output logic [15:0] out_cell_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import txc_pkg::*;

  logic [7:0] attr_r, attr_nxt;
  txc_q_t     cmd_q;
  logic       cmd_pop;
  logic       init_busy;

  assign cfg_ready = 1'b1;
  assign attr_nxt  = (cfg_valid && cfg_ready) ? cfg_data : attr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r <= ATTR_RESET;
    end else begin
      attr_r <= attr_nxt;
    end
  end

  txc_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .in_new_column (in_new_column),
    .in_new_row    (in_new_row),
    .init_busy     (init_busy),
    .cmd_pop       (cmd_pop),
    .cmd_q         (cmd_q)
  );

  txc_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .attr                (attr_r),
    .cmd_q               (cmd_q),
    .cmd_pop             (cmd_pop),
    .init_busy           (init_busy),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cursor_location (out_cursor_location),
    .out_cell_value      (out_cell_value)
  );

endmodule
